/* sv/uart_buffered_byte_channel_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the buffered byte channel
// Shared helpers; every check is clocked on clk and held off during rst.
// ---------------------------------------------------------------------------
`ifndef UART_BUFFERED_BYTE_CHANNEL_DEFINES_SVH
`define UART_BUFFERED_BYTE_CHANNEL_DEFINES_SVH

// Same-cycle implication.
`define UBBC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define UBBC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/ubbc_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ubbc_pkg
// Types, constants and ring helpers shared by the byte channel modules.
// ---------------------------------------------------------------------------
package ubbc_pkg;

  localparam int RING_DEPTH  = 256;
  localparam int PTR_W       = $clog2(RING_DEPTH);
  localparam int EXT_W       = PTR_W + 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CHAR_BS  = 8'd8;
  localparam logic [7:0] CHAR_LF  = 8'd10;
  localparam logic [7:0] CHAR_CR  = 8'd13;
  localparam logic [7:0] CHAR_SP  = 8'd32;
  localparam logic [7:0] CHAR_DEL = 8'd127;

  typedef enum logic [1:0] {
    CMD_LINE_RX  = 2'd0,
    CMD_LINE_TX  = 2'd1,
    CMD_HOST_PUT = 2'd2,
    CMD_HOST_GET = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_DROP    = 2'd1,
    STAT_REFUSED = 2'd2,
    STAT_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_PUT,
    BK_FIN
  } back_state_t;

  // Classified request: for a put, the expanded bytes in send order.
  typedef struct packed {
    cmd_t            cmd;
    logic [7:0]      data;
    logic [1:0]      need;
    logic [2:0][7:0] bytes;
  } req_t;

  function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(RING_DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ring_fill(input logic [PTR_W-1:0] wr,
                                                 input logic [PTR_W-1:0] rd);
    logic [EXT_W-1:0] sum;
    sum = EXT_W'(wr) + EXT_W'(RING_DEPTH) - EXT_W'(rd);
    if (wr >= rd) begin
      return wr - rd;
    end
    return PTR_W'(sum);
  endfunction

  function automatic logic [7:0] sat8(input logic [PTR_W-1:0] v);
    if (32'(v) > 32'd255) begin
      return 8'd255;
    end
    return 8'(v);
  endfunction

endpackage

/* sv/uart_buffered_byte_channel.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// uart_buffered_byte_channel
// Receive and transmit byte rings between a serial line and a host.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid/in_ready): command + data_byte. Command 0 pushes
//   a line byte into the receive ring, 1 pops a byte for the line (or clears
//   the tx irq enable when empty), 2 is a host put (newline -> CR LF,
//   backspace -> BS SP BS, all or nothing), 3 is a host get (CR -> LF,
//   DEL -> BS).
//   Result channel (out_valid/out_ready): exactly one result per request,
//   in request order, with status, line/host bytes, irq enable and fills.
// Sequencing:
//   The back end handles one request at a time, in states IDLE and FIN; a
//   two- or three-byte put that fits also passes through PUT for its later bytes,
//   set by the single write port of the tx ring store. Requests queue two deep in
//   front of it, so the request side keeps flowing while the back end works.
// Reset:
//   Synchronous rst empties both rings, clears the tx irq enable and drops
//   any queued request or pending result. Store contents need no clearing.
// Stalls:
//   A held result stays in the output register; the back end stops before
//   loading the next one, the queue fills, then in_ready drops.
// ---------------------------------------------------------------------------
module uart_buffered_byte_channel (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] command,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] status,
  output logic       line_valid,
  output logic [7:0] line_byte,
  output logic       host_valid,
  output logic [7:0] host_byte,
  output logic       tx_irq_on,
  output logic [7:0] rx_fill,
  output logic [7:0] tx_fill
);

  // front -> queue
  logic           push_valid;
  logic           push_ready;
  ubbc_pkg::req_t push_req;

  // queue -> back
  logic           head_valid;
  ubbc_pkg::req_t head_req;
  logic           pop;

  ubbc_pkg::status_t back_status;

  ubbc_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .data_byte  (data_byte),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_req   (push_req)
  );

  ubbc_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_req   (push_req),
    .head_valid (head_valid),
    .head_req   (head_req),
    .pop        (pop)
  );

  ubbc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head_req       (head_req),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (back_status),
    .out_line_valid (line_valid),
    .out_line_byte  (line_byte),
    .out_host_valid (host_valid),
    .out_host_byte  (host_byte),
    .out_tx_irq_on  (tx_irq_on),
    .out_rx_fill    (rx_fill),
    .out_tx_fill    (tx_fill)
  );

  assign status = 2'(back_status);

endmodule

/* sv/ubbc_fifo.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ubbc_fifo
// Short request queue between the front classifier and the back end.
// ---------------------------------------------------------------------------
module ubbc_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  ubbc_pkg::req_t push_req,
  output logic          head_valid,
  output ubbc_pkg::req_t head_req,
  input  logic          pop
);

  ubbc_pkg::req_t                  entries [ubbc_pkg::QUEUE_DEPTH];
  logic [ubbc_pkg::QPTR_W-1:0]     wr_ptr;
  logic [ubbc_pkg::QPTR_W-1:0]     rd_ptr;
  logic [ubbc_pkg::QCNT_W-1:0]     count;
  logic                            do_push;
  logic                            do_pop;

  assign push_ready = (count != ubbc_pkg::QCNT_W'(ubbc_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_req   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  function automatic logic [ubbc_pkg::QPTR_W-1:0] qnext(
      input logic [ubbc_pkg::QPTR_W-1:0] p);
    if (p == ubbc_pkg::QPTR_W'(ubbc_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + ubbc_pkg::QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= qnext(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= qnext(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + ubbc_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - ubbc_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

/* sv/ubbc_front.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ubbc_front
// Accepts requests and classifies them; expands newline and backspace puts.
// ---------------------------------------------------------------------------
module ubbc_front (
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     command,
  input  logic [7:0]     data_byte,
  output logic           push_valid,
  input  logic           push_ready,
  output ubbc_pkg::req_t push_req
);

  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  always_comb begin
    push_req.cmd  = ubbc_pkg::cmd_t'(command);
    push_req.data = data_byte;
    push_req.need = 2'd1;
    push_req.bytes[0] = data_byte;
    push_req.bytes[1] = data_byte;
    push_req.bytes[2] = data_byte;
    if (data_byte == ubbc_pkg::CHAR_LF) begin
      // newline goes out as CR LF
      push_req.need     = 2'd2;
      push_req.bytes[0] = ubbc_pkg::CHAR_CR;
      push_req.bytes[1] = ubbc_pkg::CHAR_LF;
    end else if (data_byte == ubbc_pkg::CHAR_BS) begin
      // backspace rubs out: BS, space, BS
      push_req.need     = 2'd3;
      push_req.bytes[0] = ubbc_pkg::CHAR_BS;
      push_req.bytes[1] = ubbc_pkg::CHAR_SP;
      push_req.bytes[2] = ubbc_pkg::CHAR_BS;
    end
  end

endmodule

/* sv/ubbc_back.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ubbc_back
// Ring stores, pointers and sequencer that carry out one request at a time.
// ---------------------------------------------------------------------------
`include "uart_buffered_byte_channel_defines.svh"

module ubbc_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  ubbc_pkg::req_t      head_req,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output ubbc_pkg::status_t   out_status,
  output logic                out_line_valid,
  output logic [7:0]          out_line_byte,
  output logic                out_host_valid,
  output logic [7:0]          out_host_byte,
  output logic                out_tx_irq_on,
  output logic [7:0]          out_rx_fill,
  output logic [7:0]          out_tx_fill
);

  logic [7:0] rx_store [ubbc_pkg::RING_DEPTH];
  logic [7:0] tx_store [ubbc_pkg::RING_DEPTH];

  ubbc_pkg::back_state_t state, state_next;

  logic [ubbc_pkg::PTR_W-1:0] rx_wp, rx_wp_next, rx_rp, rx_rp_next;
  logic [ubbc_pkg::PTR_W-1:0] tx_wp, tx_wp_next, tx_rp, tx_rp_next;
  logic                       tx_en, tx_en_next;
  ubbc_pkg::status_t          cur_status, cur_status_next;
  logic                       cur_lv, cur_lv_next;
  logic                       cur_hv, cur_hv_next;
  logic [1:0]                 put_idx, put_idx_next;

  logic       rx_we, rx_re, tx_we, tx_re;
  logic [7:0] tx_wdata;
  logic [7:0] rx_rdata, tx_rdata;
  logic [7:0] host_xlat;

  logic                       rx_full, rx_empty, tx_empty;
  logic [ubbc_pkg::PTR_W-1:0] tx_room;
  logic                       put_fits, put_last, load;

  assign rx_full  = (ubbc_pkg::ptr_advance(rx_wp) == rx_rp);
  assign rx_empty = (rx_wp == rx_rp);
  assign tx_empty = (tx_wp == tx_rp);
  assign tx_room  = ubbc_pkg::PTR_W'(ubbc_pkg::RING_DEPTH - 1)
                    - ubbc_pkg::ring_fill(tx_wp, tx_rp);
  assign put_fits = (ubbc_pkg::PTR_W'(head_req.need) <= tx_room);
  assign put_last = (put_idx == head_req.need - 2'd1);
  assign load     = (state == ubbc_pkg::BK_FIN) && (!out_valid || out_ready);
  assign pop      = load;

  // CR reads as LF, DEL reads as BS
  always_comb begin
    host_xlat = rx_rdata;
    if (rx_rdata == ubbc_pkg::CHAR_CR) begin
      host_xlat = ubbc_pkg::CHAR_LF;
    end else if (rx_rdata == ubbc_pkg::CHAR_DEL) begin
      host_xlat = ubbc_pkg::CHAR_BS;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ubbc_pkg::BK_IDLE: begin
        if (head_valid) begin
          if (head_req.cmd == ubbc_pkg::CMD_HOST_PUT && put_fits &&
              head_req.need != 2'd1) begin
            state_next = ubbc_pkg::BK_PUT;
          end else begin
            state_next = ubbc_pkg::BK_FIN;
          end
        end
      end
      ubbc_pkg::BK_PUT: begin
        if (put_last) begin
          state_next = ubbc_pkg::BK_FIN;
        end
      end
      ubbc_pkg::BK_FIN: begin
        if (load) begin
          state_next = ubbc_pkg::BK_IDLE;
        end
      end
      default: state_next = ubbc_pkg::BK_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    rx_wp_next      = rx_wp;
    rx_rp_next      = rx_rp;
    tx_wp_next      = tx_wp;
    tx_rp_next      = tx_rp;
    tx_en_next      = tx_en;
    cur_status_next = cur_status;
    cur_lv_next     = cur_lv;
    cur_hv_next     = cur_hv;
    put_idx_next    = put_idx;
    rx_we           = 1'b0;
    rx_re           = 1'b0;
    tx_we           = 1'b0;
    tx_re           = 1'b0;
    tx_wdata        = head_req.bytes[put_idx];
    unique case (state)
      ubbc_pkg::BK_IDLE: begin
        cur_status_next = ubbc_pkg::STAT_OK;
        cur_lv_next     = 1'b0;
        cur_hv_next     = 1'b0;
        put_idx_next    = 2'd0;
        if (head_valid) begin
          unique case (head_req.cmd)
            ubbc_pkg::CMD_LINE_RX: begin
              if (rx_full) begin
                cur_status_next = ubbc_pkg::STAT_DROP;
              end else begin
                rx_we      = 1'b1;
                rx_wp_next = ubbc_pkg::ptr_advance(rx_wp);
              end
            end
            ubbc_pkg::CMD_LINE_TX: begin
              if (tx_empty) begin
                tx_en_next = 1'b0;
              end else begin
                tx_re       = 1'b1;
                tx_rp_next  = ubbc_pkg::ptr_advance(tx_rp);
                cur_lv_next = 1'b1;
              end
            end
            ubbc_pkg::CMD_HOST_PUT: begin
              if (!put_fits) begin
                cur_status_next = ubbc_pkg::STAT_REFUSED;
              end else begin
                tx_we        = 1'b1;
                tx_wdata     = head_req.bytes[0];
                tx_wp_next   = ubbc_pkg::ptr_advance(tx_wp);
                put_idx_next = 2'd1;
                if (head_req.need == 2'd1) begin
                  tx_en_next = 1'b1;
                end
              end
            end
            ubbc_pkg::CMD_HOST_GET: begin
              if (rx_empty) begin
                cur_status_next = ubbc_pkg::STAT_EMPTY;
              end else begin
                rx_re       = 1'b1;
                rx_rp_next  = ubbc_pkg::ptr_advance(rx_rp);
                cur_hv_next = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ubbc_pkg::BK_PUT: begin
        tx_we        = 1'b1;
        tx_wp_next   = ubbc_pkg::ptr_advance(tx_wp);
        put_idx_next = put_idx + 2'd1;
        if (put_last) begin
          tx_en_next = 1'b1;
        end
      end
      ubbc_pkg::BK_FIN: ;
      default: ;
    endcase
  end

  // ring stores, one port each, registered read
  always_ff @(posedge clk) begin
    if (rx_we) begin
      rx_store[rx_wp] <= head_req.data;
    end
    if (rx_re) begin
      rx_rdata <= rx_store[rx_rp];
    end
  end

  always_ff @(posedge clk) begin
    if (tx_we) begin
      tx_store[tx_wp] <= tx_wdata;
    end
    if (tx_re) begin
      tx_rdata <= tx_store[tx_rp];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ubbc_pkg::BK_IDLE;
      rx_wp      <= '0;
      rx_rp      <= '0;
      tx_wp      <= '0;
      tx_rp      <= '0;
      tx_en      <= 1'b0;
      cur_status <= ubbc_pkg::STAT_OK;
      cur_lv     <= 1'b0;
      cur_hv     <= 1'b0;
      put_idx    <= 2'd0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      rx_wp      <= rx_wp_next;
      rx_rp      <= rx_rp_next;
      tx_wp      <= tx_wp_next;
      tx_rp      <= tx_rp_next;
      tx_en      <= tx_en_next;
      cur_status <= cur_status_next;
      cur_lv     <= cur_lv_next;
      cur_hv     <= cur_hv_next;
      put_idx    <= put_idx_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (load) begin
      out_status     <= cur_status;
      out_line_valid <= cur_lv;
      out_line_byte  <= cur_lv ? tx_rdata : 8'd0;
      out_host_valid <= cur_hv;
      out_host_byte  <= cur_hv ? host_xlat : 8'd0;
      out_tx_irq_on  <= tx_en;
      out_rx_fill    <= ubbc_pkg::sat8(ubbc_pkg::ring_fill(rx_wp, rx_rp));
      out_tx_fill    <= ubbc_pkg::sat8(ubbc_pkg::ring_fill(tx_wp, tx_rp));
    end
  end

  `UBBC_ASSERT_NOW(a_rx_no_overrun, rx_we, ubbc_pkg::ptr_advance(rx_wp) != rx_rp, "rx ring overrun")
  `UBBC_ASSERT_NOW(a_tx_no_overrun, tx_we, ubbc_pkg::ptr_advance(tx_wp) != tx_rp, "tx ring overrun")
  `UBBC_ASSERT_NOW(a_put_cmd, state == ubbc_pkg::BK_PUT, head_valid && head_req.cmd == ubbc_pkg::CMD_HOST_PUT, "put burst without put request")
  `UBBC_ASSERT_NOW(a_put_idx, state == ubbc_pkg::BK_PUT, put_idx < head_req.need, "put index past expansion")
  `UBBC_ASSERT_NEXT(a_put_sets_irq, (state == ubbc_pkg::BK_PUT) && put_last, tx_en, "put did not enable tx irq")

endmodule
